### rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// shared constants for the rc4 stream cipher engine
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int PERM_DEPTH  = 256;
  localparam int KEY_DEPTH   = 256;
  localparam int KEY_CNT_W   = 9;

  // transaction kinds carried on tuser
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_DATA = 1'b1;

endpackage

### rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// rc4 engine: key bytes fill a key store, the end mark runs the key schedule,
// data bytes leave xored with the next keystream byte
// ----------------------------------------------------------------------------
//  channel  direction  tdata              tuser      tlast
//  in_      slave      [7:0] data_byte    [0] action  end_mark
//  out_     master     [7:0] out_byte     -           last_out
//
//  key byte: taken in idle; the end-marked key byte starts the key schedule,
//  256 rounds of read, index and two write states, with in_tready held low
//  data byte: read i, read j, two swap states and the output state run
//  in order, set by the single read and single write port of the permutation
//  memory; a full output register holds the engine in its last data state
//  a result waits in the output register while the next transaction is taken
//  reset: synchronous, active low; permutation reads as identity through
//  per-entry valid flops, indices and key count cleared
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] action
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_K_RD,
    S_K_J,
    S_K_W1,
    S_K_W2,
    S_D_RDI,
    S_D_RDJ,
    S_D_SW1,
    S_D_SW2,
    S_D_OUT
  } state_t;

  typedef logic [rc4_pkg::BYTE_W-1:0] byte_t;

  state_t                          state_r;
  byte_t                           gen_i_r;
  byte_t                           gen_j_r;
  logic [rc4_pkg::KEY_CNT_W-1:0]   key_cnt_r;
  logic [rc4_pkg::KEY_CNT_W-1:0]   key_len_r;
  byte_t                           k_r;
  byte_t                           pos_r;
  byte_t                           si_r;
  byte_t                           sj_r;
  byte_t                           t_r;
  byte_t                           data_r;
  logic                            mark_r;
  byte_t                           ks_r;
  logic                            out_valid_r;
  byte_t                           out_data_r;
  logic                            out_last_r;
  logic [rc4_pkg::PERM_DEPTH-1:0]  perm_vld_r;

  byte_t                           perm_mem [rc4_pkg::PERM_DEPTH];
  byte_t                           key_mem  [rc4_pkg::KEY_DEPTH];

  byte_t                           perm_rd_q;
  byte_t                           perm_raddr_q;
  logic                            perm_rvld_q;
  byte_t                           key_rd_q;

  logic                            perm_re;
  byte_t                           perm_raddr;
  logic                            perm_we;
  byte_t                           perm_waddr;
  byte_t                           perm_wdata;
  logic                            key_we;
  byte_t                           perm_val;
  byte_t                           j_nxt;
  logic                            in_acc;
  logic [rc4_pkg::KEY_CNT_W-1:0]   key_cnt_nxt;
  logic [rc4_pkg::KEY_CNT_W-1:0]   pos_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // entry never written since reset or schedule start reads as its index
  assign perm_val = perm_rvld_q ? perm_rd_q : perm_raddr_q;

  assign key_we      = in_acc && (in_tuser == rc4_pkg::ACT_KEY) && !key_cnt_r[8];
  assign key_cnt_nxt = key_we ? key_cnt_r + 9'd1 : key_cnt_r;
  assign pos_inc     = {1'b0, pos_r} + 9'd1;

  always_comb begin
    perm_re    = 1'b0;
    perm_raddr = '0;
    perm_we    = 1'b0;
    perm_waddr = '0;
    perm_wdata = '0;
    j_nxt      = gen_j_r;
    unique case (state_r)
      S_K_RD: begin
        perm_re    = 1'b1;
        perm_raddr = k_r;
      end
      S_K_J: begin
        j_nxt      = gen_j_r + key_rd_q + perm_val;
        perm_re    = 1'b1;
        perm_raddr = j_nxt;
      end
      S_K_W1: begin
        perm_we    = 1'b1;
        perm_waddr = k_r;
        perm_wdata = perm_val;
      end
      S_K_W2: begin
        perm_we    = 1'b1;
        perm_waddr = gen_j_r;
        perm_wdata = si_r;
      end
      S_D_RDI: begin
        perm_re    = 1'b1;
        perm_raddr = gen_i_r;
      end
      S_D_RDJ: begin
        j_nxt      = gen_j_r + perm_val;
        perm_re    = 1'b1;
        perm_raddr = j_nxt;
      end
      S_D_SW1: begin
        perm_we    = 1'b1;
        perm_waddr = gen_i_r;
        perm_wdata = perm_val;
        perm_re    = 1'b1;
        perm_raddr = si_r + perm_val;
      end
      S_D_SW2: begin
        perm_we    = 1'b1;
        perm_waddr = gen_j_r;
        perm_wdata = si_r;
      end
      S_IDLE, S_D_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // permutation memory
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd_q    <= perm_mem[perm_raddr];
      perm_raddr_q <= perm_raddr;
      perm_rvld_q  <= perm_vld_r[perm_raddr];
    end
  end

  // key store
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_cnt_r[7:0]] <= in_tdata;
    end
    if (state_r == S_K_RD) begin
      key_rd_q <= key_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_i_r     <= '0;
      gen_j_r     <= '0;
      key_cnt_r   <= '0;
      key_len_r   <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      perm_vld_r  <= '0;
    end else begin
      if (out_tready && state_r != S_D_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (perm_we) begin
        perm_vld_r[perm_waddr] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == rc4_pkg::ACT_KEY) begin
              if (in_tlast) begin
                key_len_r  <= key_cnt_nxt;
                key_cnt_r  <= '0;
                k_r        <= '0;
                pos_r      <= '0;
                gen_i_r    <= '0;
                gen_j_r    <= '0;
                perm_vld_r <= '0;
                state_r    <= S_K_RD;
              end else begin
                key_cnt_r <= key_cnt_nxt;
              end
            end else begin
              gen_i_r <= gen_i_r + 8'd1;
              data_r  <= in_tdata;
              mark_r  <= in_tlast;
              state_r <= S_D_RDI;
            end
          end
        end
        S_K_RD: begin
          state_r <= S_K_J;
        end
        S_K_J: begin
          gen_j_r <= j_nxt;
          si_r    <= perm_val;
          state_r <= S_K_W1;
        end
        S_K_W1: begin
          state_r <= S_K_W2;
        end
        S_K_W2: begin
          pos_r <= (pos_inc >= key_len_r) ? '0 : pos_inc[7:0];
          if (k_r == 8'hff) begin
            gen_i_r <= '0;
            gen_j_r <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 8'd1;
            state_r <= S_K_RD;
          end
        end
        S_D_RDI: begin
          state_r <= S_D_RDJ;
        end
        S_D_RDJ: begin
          gen_j_r <= j_nxt;
          si_r    <= perm_val;
          state_r <= S_D_SW1;
        end
        S_D_SW1: begin
          sj_r    <= perm_val;
          t_r     <= si_r + perm_val;
          state_r <= S_D_SW2;
        end
        S_D_SW2: begin
          // lookup was read before the swap landed
          priority if (t_r == gen_j_r) begin
            ks_r <= si_r;
          end else if (t_r == gen_i_r) begin
            ks_r <= sj_r;
          end else begin
            ks_r <= perm_val;
          end
          state_r <= S_D_OUT;
        end
        S_D_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= data_r ^ ks_r;
            out_last_r  <= mark_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_key_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_cnt_r <= 9'd256)
    else $error("key count past key store depth");

  a_key_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == rc4_pkg::ACT_KEY) && in_tlast
    |=> state_r == S_K_RD && key_cnt_r == '0 && perm_vld_r == '0)
    else $error("end-marked key byte did not start the schedule");

  a_data_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == rc4_pkg::ACT_DATA)
    |=> state_r == S_D_RDI && gen_i_r == 8'($past(gen_i_r) + 8'd1))
    else $error("data transaction did not advance the generator");

  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_K_W2 && k_r == 8'hff
    |=> state_r == S_IDLE && gen_i_r == '0 && gen_j_r == '0)
    else $error("schedule did not finish with cleared indices");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_D_OUT && (!out_valid_r || out_tready)
    |=> out_valid_r && out_data_r == ($past(data_r) ^ $past(ks_r)))
    else $error("result not loaded into the output register");
`endif

endmodule

### tb/rc4_stream_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// self-checking bench for the rc4 engine: key and data transactions are
// streamed in under random gaps and output back-pressure, a built-in rc4
// model tracks the permutation and key store, and every output transaction
// is compared with the byte and end mark that the model predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc4_stream_cipher_tb;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 64;
  localparam int RANDOM_ITEMS   = 220;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = rc4_pkg::ACT_KEY;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // model state
  logic [7:0]     sbox [rc4_pkg::PERM_DEPTH];
  logic [7:0]     key_buf [rc4_pkg::KEY_DEPTH];
  int             key_len;
  logic [7:0]     idx_i;
  logic [7:0]     idx_j;
  cipher_out_t    keystream_q [$];

  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int hold_cycles = 0;
  int mismatches  = 0;
  int stall_count = 0;
  int items_sent  = 0;
  int key_bytes   = 0;
  int data_bytes  = 0;
  int schedules   = 0;
  int dropped_key = 0;
  int checked     = 0;

  rc4_stream_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  task automatic run_key_schedule();
    int         k;
    int         pos;
    int         len;
    logic [7:0] j;
    logic [7:0] kb;
    logic [7:0] t;
    len = key_len;
    pos = 0;
    j   = '0;
    for (k = 0; k < rc4_pkg::PERM_DEPTH; k++) sbox[k] = k[7:0];
    for (k = 0; k < rc4_pkg::PERM_DEPTH; k++) begin
      kb = (len != 0) ? key_buf[pos] : 8'h00;
      j = j + kb + sbox[k];
      t = sbox[k];
      sbox[k] = sbox[j];
      sbox[j] = t;
      pos++;
      if (len == 0 || pos >= len) pos = 0;
    end
    idx_i   = '0;
    idx_j   = '0;
    key_len = 0;
    schedules++;
  endtask

  task automatic rc4_absorb(input logic act, input logic [7:0] b, input logic mark);
    logic [7:0]  t;
    logic [7:0]  sum;
    cipher_out_t res;
    if (act == rc4_pkg::ACT_KEY) begin
      key_bytes++;
      if (key_len < rc4_pkg::KEY_DEPTH) begin
        key_buf[key_len] = b;
        key_len++;
      end else begin
        dropped_key++;
      end
      if (mark) run_key_schedule();
    end else begin
      data_bytes++;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      sum = sbox[idx_i] + sbox[idx_j];
      res.data = b ^ sbox[sum];
      res.last = mark;
      keystream_q.push_back(res);
    end
  endtask

  task automatic send_item(input logic act, input logic [7:0] b, input logic mark);
    @(negedge clk);
    while (in_idle_en && $urandom_range(0, 99) < 9) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = b;
    in_tlast  = mark;
    do @(posedge clk); while (!in_tready);
    rc4_absorb(act, b, mark);
    items_sent++;
  endtask

  task automatic send_key(input int len, input bit closed);
    for (int n = 0; n < len; n++)
      send_item(rc4_pkg::ACT_KEY, 8'($urandom_range(0, 255)), closed && (n == len - 1));
  endtask

  task automatic send_buffer(input int len);
    for (int n = 0; n < len; n++)
      send_item(rc4_pkg::ACT_DATA, 8'($urandom_range(0, 255)), n == len - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (keystream_q.size() != 0) @(posedge clk);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready = !(out_idle_en && $urandom_range(0, 99) < 9);
    end
  end

  // output checker
  always @(posedge clk) begin
    cipher_out_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (keystream_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output transaction: byte %02h last %0b", out_tdata, out_tlast);
      end else begin
        exp_res = keystream_q.pop_front();
        checked++;
        if (out_tdata !== exp_res.data || out_tlast !== exp_res.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     checked, exp_res.data, exp_res.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_count);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic test_identity_perm();
    send_item(rc4_pkg::ACT_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::ACT_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::ACT_DATA, 8'hA5, 1'b0);
    send_item(rc4_pkg::ACT_DATA, 8'h5A, 1'b1);
  endtask

  task automatic test_single_byte_key();
    send_item(rc4_pkg::ACT_KEY, 8'h00, 1'b1);
    send_buffer(3);
    send_item(rc4_pkg::ACT_KEY, 8'hFF, 1'b1);
    send_item(rc4_pkg::ACT_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::ACT_DATA, 8'h00, 1'b1);
  endtask

  task automatic test_partial_key();
    send_item(rc4_pkg::ACT_KEY, 8'h01, 1'b0);
    send_item(rc4_pkg::ACT_KEY, 8'h80, 1'b0);
    send_buffer(2);
    send_item(rc4_pkg::ACT_KEY, 8'h7F, 1'b1);
    send_buffer(2);
  endtask

  task automatic test_key_overflow();
    send_key(rc4_pkg::KEY_DEPTH, 1'b1);
    send_buffer(3);
    send_key(rc4_pkg::KEY_DEPTH + 5, 1'b1);
    send_buffer(3);
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_cycles = 300;
    send_buffer(24);
    wait_drained();
    send_key(5, 1'b1);
    send_buffer(8);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      in_idle_en  = !(items_sent - start >= 60 && items_sent - start < 160);
      out_idle_en = in_idle_en;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 16);
        send_key(len, 1'b1);
        send_buffer($urandom_range(1, 24));
      end else if (pick < 70) begin
        send_buffer($urandom_range(1, 24));
      end else if (pick < 85) begin
        send_item(rc4_pkg::ACT_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_key($urandom_range(1, 4), 1'b0);
        send_buffer($urandom_range(1, 6));
        send_key($urandom_range(1, 4), 1'b1);
      end
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < rc4_pkg::PERM_DEPTH; k++) begin
      sbox[k]    = k[7:0];
      key_buf[k] = '0;
    end
    key_len = 0;
    idx_i   = '0;
    idx_j   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_identity_perm();
    test_single_byte_key();
    test_partial_key();
    test_key_overflow();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (keystream_q.size() != 0) mismatches++;

    $display("run covered %0d key bytes (%0d beyond the key store), %0d key schedules,",
             key_bytes, dropped_key, schedules);
    $display("and %0d data bytes checked against the model with %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
